@@ rtl/ccc_pkg.sv @@
// ----------------------------------------------------------------------------
// ccc_pkg
// Types and constants shared by the circle centre from chord unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ccc_pkg;

  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned TAIL_DEPTH = DIV_STEPS + SQRT_STEPS;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_SAME  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic        [30:0] radius;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic        [1:0]  status;
  } out_item_t;

  // travels alongside the divider and root stages
  typedef struct packed {
    logic signed [32:0] sum_x;
    logic signed [32:0] sum_y;
    logic               neg_x;
    logic               neg_y;
    status_e            status;
  } side_t;

endpackage

`default_nettype wire

@@ rtl/ccc_if.sv @@
// ----------------------------------------------------------------------------
// ccc_in_if / ccc_out_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccc_in_if import ccc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ccc_out_if import ccc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/ccc_front.sv @@
// ----------------------------------------------------------------------------
// ccc_front
// Chord deltas, squared lengths, status and the p^2 * D numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module ccc_front import ccc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic         valid_i,
  input  wire in_item_t     item_i,
  output logic              valid_o,
  output side_t             side_o,
  output logic [127:0]      num_x_o,
  output logic [127:0]      num_y_o,
  output logic [63:0]       den_o
);

  // stage 1
  logic               v1_q;
  logic signed [32:0] a_q, b_q, sx1_q, sy1_q;
  logic        [30:0] r1_q;
  // stage 2
  logic               v2_q;
  logic        [65:0] aa_q, bb_q;
  logic        [61:0] rr_q;
  logic               negx2_q, negy2_q;
  logic signed [32:0] sx2_q, sy2_q;
  // stage 3
  logic               v3_q;
  side_t              side3_q;
  logic        [63:0] s3_q, d3_q, px2_q, py2_q;
  // stage 4
  logic               v4_q;
  side_t              side4_q;
  logic        [63:0] s4_q;
  logic        [63:0] xll_q, xlh_q, xhl_q, xhh_q;
  logic        [63:0] yll_q, ylh_q, yhl_q, yhh_q;
  // stage 5
  logic               v5_q;
  side_t              side5_q;
  logic        [63:0] s5_q;
  logic        [127:0] nx5_q, ny5_q;

  logic        [32:0] a_mag, b_mag;
  logic        [66:0] s_full;
  logic        [63:0] r4;
  status_e            st_d;

  assign a_mag  = a_q[32] ? 33'(-a_q) : 33'(a_q);
  assign b_mag  = b_q[32] ? 33'(-b_q) : 33'(b_q);
  assign s_full = {1'b0, aa_q} + {1'b0, bb_q};
  assign r4     = {rr_q, 2'b00};

  always_comb begin
    priority if (s_full == 67'd0) begin
      st_d = ST_SAME;
    end else if (s_full > {3'b000, r4}) begin
      st_d = ST_SHORT;
    end else begin
      st_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= 33'(item_i.first_x) - 33'(item_i.second_x);
      b_q   <= 33'(item_i.first_y) - 33'(item_i.second_y);
      sx1_q <= 33'(item_i.first_x) + 33'(item_i.second_x);
      sy1_q <= 33'(item_i.first_y) + 33'(item_i.second_y);
      r1_q  <= item_i.radius;

      aa_q    <= a_mag * a_mag;
      bb_q    <= b_mag * b_mag;
      rr_q    <= r1_q * r1_q;
      // x offset uses +-b, y offset uses -+a
      negx2_q <= (a_q > 33'sd0) ? b_q[32] : (b_q > 33'sd0);
      negy2_q <= (a_q != 33'sd0);
      sx2_q   <= sx1_q;
      sy2_q   <= sy1_q;

      side3_q.sum_x  <= sx2_q;
      side3_q.sum_y  <= sy2_q;
      side3_q.neg_x  <= negx2_q;
      side3_q.neg_y  <= negy2_q;
      side3_q.status <= st_d;
      s3_q  <= s_full[63:0];
      d3_q  <= r4 - s_full[63:0];
      px2_q <= bb_q[63:0];
      py2_q <= aa_q[63:0];

      side4_q <= side3_q;
      s4_q    <= s3_q;
      xll_q   <= px2_q[31:0]  * d3_q[31:0];
      xlh_q   <= px2_q[31:0]  * d3_q[63:32];
      xhl_q   <= px2_q[63:32] * d3_q[31:0];
      xhh_q   <= px2_q[63:32] * d3_q[63:32];
      yll_q   <= py2_q[31:0]  * d3_q[31:0];
      ylh_q   <= py2_q[31:0]  * d3_q[63:32];
      yhl_q   <= py2_q[63:32] * d3_q[31:0];
      yhh_q   <= py2_q[63:32] * d3_q[63:32];

      side5_q <= side4_q;
      s5_q    <= s4_q;
      nx5_q   <= {xhh_q, xll_q} + {32'd0, xlh_q, 32'd0} + {32'd0, xhl_q, 32'd0};
      ny5_q   <= {yhh_q, yll_q} + {32'd0, ylh_q, 32'd0} + {32'd0, yhl_q, 32'd0};
    end
  end

  assign valid_o = v5_q;
  assign side_o  = side5_q;
  assign num_x_o = nx5_q;
  assign num_y_o = ny5_q;
  assign den_o   = s5_q;

endmodule

`default_nettype wire

@@ rtl/ccc_div.sv @@
// ----------------------------------------------------------------------------
// ccc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ccc_div import ccc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [127:0] num_i,
  input  wire logic [63:0]  den_i,
  output logic      [63:0]  quot_o
);

  logic [63:0] rem_q [DIV_STEPS];
  logic [63:0] lo_q  [DIV_STEPS];
  logic [63:0] quo_q [DIV_STEPS];
  logic [63:0] den_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [63:0] rem_in, lo_in, quo_in, den_in;
    logic [64:0] rem_sh;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i[127:64];
      assign lo_in  = num_i[63:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign rem_sh = {rem_in, lo_in[63]};
    assign ge     = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? 64'(rem_sh - {1'b0, den_in}) : rem_sh[63:0];
        lo_q[k]  <= {lo_in[62:0], 1'b0};
        quo_q[k] <= {quo_in[62:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quot_o = quo_q[DIV_STEPS-1];

endmodule

`default_nettype wire

@@ rtl/ccc_sqrt.sv @@
// ----------------------------------------------------------------------------
// ccc_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ccc_sqrt import ccc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] rad_i,
  output logic      [31:0] root_o
);

  logic [63:0] rad_q  [SQRT_STEPS];
  logic [33:0] rem_q  [SQRT_STEPS];
  logic [31:0] root_q [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    logic [63:0] rad_in;
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [35:0] rem_sh, trial;
    logic        ge;

    if (j == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    assign rem_sh = {rem_in, rad_in[63:62]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[j]  <= {rad_in[61:0], 2'b00};
        rem_q[j]  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
        root_q[j] <= {root_in[30:0], ge};
      end
    end
  end

  assign root_o = root_q[SQRT_STEPS-1];

endmodule

`default_nettype wire

@@ rtl/circle_center_from_chord_unit.sv @@
// ----------------------------------------------------------------------------
// circle_center_from_chord_unit
// Centre of a circle of given radius through two points, signed Q16.16.
//
// Usage: items enter on in_i (two points and a radius) and leave on out_o
// (centre x, centre y, status) with a valid/ready handshake each.
// Status 0 is a good centre; 1 flags a radius shorter than the half chord and
// 2 flags coinciding points, both with a zero centre. Coordinates saturate.
// The path from acceptance to the result being shown runs through five
// front stages (chord deltas, squares, status, partial products, sum), a
// 64-stage divider giving p^2*D/S, a 32-stage square root and the output
// register. One item is accepted every cycle while shown results are taken.
// The whole pipeline advances together: while a shown result is not taken,
// every stage holds and in_i.ready is low; nothing is dropped or repeated.
// Reset clears all valid bits, so the block comes out of reset empty and
// ready.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_center_from_chord_unit import ccc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ccc_in_if.sink     in_i,
  ccc_out_if.source  out_o
);

  logic         adv;
  logic         fr_valid;
  side_t        fr_side;
  logic [127:0] num_x, num_y;
  logic [63:0]  den;
  logic [63:0]  quot_x, quot_y;
  logic [31:0]  root_x, root_y;

  logic         tv_q   [TAIL_DEPTH];
  side_t        side_q [TAIL_DEPTH];

  logic         out_valid_q;
  out_item_t    out_item_q, out_item_d;

  assign adv         = !out_valid_q || out_o.ready;
  assign in_i.ready  = adv;

  ccc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_i.valid),
    .item_i  (in_i.data),
    .valid_o (fr_valid),
    .side_o  (fr_side),
    .num_x_o (num_x),
    .num_y_o (num_y),
    .den_o   (den)
  );

  ccc_div u_div_x (.clk_i(clk_i), .en_i(adv), .num_i(num_x), .den_i(den), .quot_o(quot_x));
  ccc_div u_div_y (.clk_i(clk_i), .en_i(adv), .num_i(num_y), .den_i(den), .quot_o(quot_y));

  ccc_sqrt u_sqrt_x (.clk_i(clk_i), .en_i(adv), .rad_i(quot_x), .root_o(root_x));
  ccc_sqrt u_sqrt_y (.clk_i(clk_i), .en_i(adv), .rad_i(quot_y), .root_o(root_y));

  for (genvar k = 0; k < TAIL_DEPTH; k++) begin : g_tail
    logic  v_in;
    side_t s_in;
    if (k == 0) begin : g_first
      assign v_in = fr_valid;
      assign s_in = fr_side;
    end else begin : g_next
      assign v_in = tv_q[k-1];
      assign s_in = side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tv_q[k] <= 1'b0;
      end else if (adv) begin
        tv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[k] <= s_in;
      end
    end
  end

  // centre = floor((p1 + p2 + offset) / 2), saturated
  function automatic logic signed [31:0] ccc_centre(logic signed [32:0] sum,
                                                    logic neg, logic [31:0] root);
    logic signed [32:0] off;
    logic signed [34:0] t, h;
    off = neg ? -$signed({1'b0, root}) : $signed({1'b0, root});
    t   = 35'(sum) + 35'(off);
    h   = t >>> 1;
    if (h > 35'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (h < -35'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return h[31:0];
    end
  endfunction

  always_comb begin
    side_t s;
    s = side_q[TAIL_DEPTH-1];
    out_item_d.status = s.status;
    if (s.status == ST_OK) begin
      out_item_d.center_x = ccc_centre(s.sum_x, s.neg_x, root_x);
      out_item_d.center_y = ccc_centre(s.sum_y, s.neg_y, root_y);
    end else begin
      out_item_d.center_x = '0;
      out_item_d.center_y = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tv_q[TAIL_DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

endmodule

`default_nettype wire

@@ dv/tb_circle_center_from_chord_unit.sv @@
// ----------------------------------------------------------------------------
// tb_circle_center_from_chord_unit
// Self-checking bench for the circle centre from chord unit.
//
// A driver feeds point pairs and radii from a queue and a monitor compares
// every result with a centre computed here in exact integer arithmetic.
// Idling on each side is varied over three phases, with one hold-off until
// the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_circle_center_from_chord_unit;
  import ccc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ccc_in_if  in_ch ();
  ccc_out_if out_ch ();

  circle_center_from_chord_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #6 clk_i = ~clk_i;

  in_item_t  pending_q[$];
  out_item_t centre_q[$];
  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 72;
  bit          hold_off = 1'b0;
  bit          failed = 1'b0;
  bit          in_fire = 1'b0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_ok = 0, n_short = 0, n_same = 0;

  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint perp_offset(longint p, logic [63:0] d, logic [63:0] s);
    logic [127:0] num;
    logic [63:0]  q, root;
    logic [63:0]  m;
    m = (p < 0) ? -p : p;
    num = {64'd0, m * m} * {64'd0, d};
    q = num / {64'd0, s};
    root = root_floor(q);
    return (p < 0) ? -longint'(root) : longint'(root);
  endfunction

  function automatic logic [31:0] half_sat(longint t);
    longint h;
    h = t >>> 1;
    if (h > 64'sd2147483647) h = 64'sd2147483647;
    if (h < -64'sd2147483648) h = -64'sd2147483648;
    return h[31:0];
  endfunction

  function automatic out_item_t centre_of(in_item_t it);
    out_item_t   o;
    longint      x1, y1, x2, y2, a, b, px, py;
    logic [63:0] aa, bb, s, r4, d;
    logic [64:0] s_wide;
    x1 = it.first_x; y1 = it.first_y; x2 = it.second_x; y2 = it.second_y;
    a = x1 - x2;
    b = y1 - y2;
    aa = (a < 0 ? -a : a) * (a < 0 ? -a : a);
    bb = (b < 0 ? -b : b) * (b < 0 ? -b : b);
    s_wide = {1'b0, aa} + {1'b0, bb};
    s = s_wide[63:0];
    r4 = ({33'd0, it.radius} * {33'd0, it.radius}) << 2;
    o = '0;
    if (s_wide == 0) begin
      o.status = ST_SAME;
    end else if (s_wide[64] || s > r4) begin
      o.status = ST_SHORT;
    end else begin
      d = r4 - s;
      if (a > 0) begin
        px = b; py = -a;
      end else begin
        px = -b; py = a;
      end
      o.center_x = half_sat(x1 + x2 + perp_offset(px, d, s));
      o.center_y = half_sat(y1 + y2 + perp_offset(py, d, s));
      o.status = ST_OK;
    end
    return o;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return $urandom_range(0, 4000) - 2000;
      default: return ($urandom() >>> $urandom_range(0, 24));
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t    it;
    longint      dx, dy;
    logic [63:0] hc;
    it.first_x = rand_coord();
    it.first_y = rand_coord();
    case ($urandom_range(0, 9))
      0: begin
        it.second_x = it.first_x;
        it.second_y = it.first_y;
      end
      1, 2: begin
        it.second_x = rand_coord();
        it.second_y = rand_coord();
      end
      default: begin
        it.second_x = it.first_x + (($urandom() >>> $urandom_range(1, 31)) ^
                      ($urandom_range(0, 1) ? 32'hffffffff : 0));
        it.second_y = it.first_y + (($urandom() >>> $urandom_range(1, 31)) ^
                      ($urandom_range(0, 1) ? 32'hffffffff : 0));
      end
    endcase
    dx = longint'(it.first_x) - longint'(it.second_x);
    dy = longint'(it.first_y) - longint'(it.second_y);
    hc = root_floor((dx < 0 ? -dx : dx) * (dx < 0 ? -dx : dx) / 4 +
                    (dy < 0 ? -dy : dy) * (dy < 0 ? -dy : dy) / 4);
    case ($urandom_range(0, 7))
      0: it.radius = 31'($urandom());
      1: it.radius = (hc > 64'h7fffffff) ? 31'h7fffffff : hc[30:0];
      2: it.radius = 31'((hc > 64'h7ffffffe || hc == 0) ? $urandom() : hc[30:0] - 1);
      default: begin
        hc = hc + ($urandom() >> $urandom_range(0, 31));
        it.radius = (hc > 64'h7fffffff) ? 31'h7fffffff : hc[30:0];
      end
    endcase
    return it;
  endfunction

  function automatic in_item_t mk(int x1, int y1, int x2, int y2, int r);
    in_item_t it;
    it.first_x = x1; it.first_y = y1; it.second_x = x2; it.second_y = y2;
    it.radius = r[30:0];
    return it;
  endfunction

  // handshake as seen at the accepting edge
  always @(posedge clk_i) begin
    in_fire <= in_ch.valid && in_ch.ready;
  end

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_fire) begin
        centre_q.push_back(centre_of(in_ch.data));
        n_sent++;
      end
      if ((in_ch.valid && !in_fire) ||
          (pending_q.size() != 0 && !hold_off && $urandom_range(0, 99) >= send_idle_pct)) begin
        if (!(in_ch.valid && !in_fire)) begin
          in_ch.data <= pending_q.pop_front();
        end
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t exp_o;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (centre_q.size() == 0) begin
        $error("result with no item outstanding");
        failed = 1'b1;
      end else begin
        exp_o = centre_q.pop_front();
        if (out_ch.data.center_x !== exp_o.center_x) begin
          $error("center_x expected %0d got %0d", exp_o.center_x, out_ch.data.center_x);
          failed = 1'b1;
        end
        if (out_ch.data.center_y !== exp_o.center_y) begin
          $error("center_y expected %0d got %0d", exp_o.center_y, out_ch.data.center_y);
          failed = 1'b1;
        end
        if (out_ch.data.status !== exp_o.status) begin
          $error("status expected %0d got %0d", exp_o.status, out_ch.data.status);
          failed = 1'b1;
        end
        case (exp_o.status)
          ST_OK:    n_ok++;
          ST_SHORT: n_short++;
          default:  n_same++;
        endcase
        n_checked++;
      end
    end
  end

  task automatic wait_empty();
    while (pending_q.size() != 0 || in_ch.valid || centre_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned total;
    out_ch.ready = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    // directed: extremes, coinciding points, radius zero, exact half chord
    pending_q.push_back(mk(0, 0, 0, 0, 0));
    pending_q.push_back(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                           32'h7fffffff));
    pending_q.push_back(mk(32'h00020000, 0, 0, 0, 32'h00010000));
    pending_q.push_back(mk(0, 0, 32'h00020000, 0, 32'h00010000));
    pending_q.push_back(mk(32'h00020000, 0, 0, 0, 32'h0000ffff));
    pending_q.push_back(mk(32'h00020000, 0, 0, 0, 32'h00020000));
    pending_q.push_back(mk(0, 0, 32'h00020000, 0, 32'h00020000));
    pending_q.push_back(mk(0, 32'h00020000, 0, 0, 32'h00050000));
    pending_q.push_back(mk(0, 0, 0, 32'h00020000, 32'h00050000));
    pending_q.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                           32'h7fffffff));
    pending_q.push_back(mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0));
    pending_q.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7ffffff0, 32'h7fffffff,
                           32'h7fffffff));
    pending_q.push_back(mk(32'h80000000, 32'h80000000, 32'h80000010, 32'h80000000,
                           32'h7fffffff));
    pending_q.push_back(mk(1, 0, 0, 0, 32'h7fffffff));
    pending_q.push_back(mk(32'hffffffff, 32'hffffffff, 0, 0, 1));
    pending_q.push_back(mk(3, 4, 0, 0, 0));
    pending_q.push_back(mk(32'h00030000, 32'h00040000, 0, 0, 32'h00028000));
    pending_q.push_back(mk(32'h55555555, 32'haaaaaaaa, 32'h55555554, 32'haaaaaaab,
                           32'h2aaaaaaa));
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    total = 1050;
    for (int unsigned ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 72; recv_idle_pct = 9;
      end else if (ph == 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int unsigned i = 0; i < total / 3; i++) pending_q.push_back(rand_item());
      if (ph == 1) begin
        while (pending_q.size() > 150) @(posedge clk_i);
        hold_off = 1'b1;
        while (in_ch.valid || centre_q.size() != 0) @(posedge clk_i);
        hold_off = 1'b0;
      end
      wait_empty();
    end
    repeat (120) @(posedge clk_i);
    $display("checked %0d results over %0d items: %0d centres, %0d short radius, %0d same point",
             n_checked, n_sent, n_ok, n_short, n_same);
    $display("three idling phases with one drain hold-off");
    if (!failed && centre_q.size() == 0) begin
      $display("circle_center_from_chord_unit test passed");
    end else begin
      $display("circle_center_from_chord_unit test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("circle_center_from_chord_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
